// File: rtl/assert_macros.svh
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define LPHM_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("Assertion failed.");

// Checks that a consequent holds whenever an antecedent holds.
`define LPHM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("Assertion failed.");

// Checks that a consequent holds in the cycle after an antecedent.
`define LPHM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("Assertion failed.");

`endif

// File: rtl/lphm_pkg.sv
// Types, codes and constants of the linear probing hash map.
package lphm_pkg;

  localparam int unsigned SLOTS_DEFAULT = 1024;
  localparam int unsigned LIMIT_W       = 10;
  localparam logic [LIMIT_W-1:0] OCC_LIMIT_RST  = 10'd716;
  localparam logic [LIMIT_W-1:0] TOMB_LIMIT_RST = 10'd204;
  localparam logic [31:0] NEW_VALUE = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    F_FIND   = 3'd0,
    F_INSERT = 3'd1,
    F_WRITE  = 3'd2,
    F_ERASE  = 3'd3,
    F_CLEAR  = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ST_FOUND    = 3'd0,
    ST_INSERTED = 3'd1,
    ST_ABSENT   = 3'd2,
    ST_FULL     = 3'd3,
    ST_REMOVED  = 3'd4
  } status_t;

  typedef enum logic {
    REG_OCC_LIMIT  = 1'b0,
    REG_TOMB_LIMIT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    TAG_LIVE  = 2'b00,
    TAG_EMPTY = 2'b10,
    TAG_DEL   = 2'b11
  } tag_t;

  typedef struct packed {
    tag_t        tag;
    logic [30:0] key;
    logic [31:0] value;
  } entry_t;

endpackage

// File: rtl/lphm_ram.sv
// Simple dual-port table memory with a registered read.
module lphm_ram #(
  parameter int unsigned W     = 65,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/linear_probe_hash_map.sv
// Top level of the linear probing hash map: control sequencer and two table banks.
//
// Requests enter on the in_ channel (in_valid, in_stall) carrying a function code,
// a 31-bit key and a 32-bit value. Each request produces exactly one response on
// the out_ channel (out_valid, out_stall) with a status, the entry value and the
// live entry count. The user must write registers on the cfg_ channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data) only while no request is in flight; the block
// itself does not enforce this. One request is processed at a time. A find,
// insert, write or erase probes one slot at a time, limited by the single read
// port of the active bank, and a clear sweeps every slot of the active bank to
// empty. The sequencer passes through a response state before it takes the next
// request. An erase that triggers a rebuild then sweeps the spare bank to empty,
// scans each slot of the active bank and rehashes every live entry into the spare
// bank by linear probing; the banks then swap roles. After reset the active bank
// is swept to empty while in_stall stays high. A finished response sits in an
// output register; a new request is accepted while it waits, and the next
// response holds in the sequencer until out_stall falls.
module linear_probe_hash_map #(
  parameter int unsigned SLOTS = lphm_pkg::SLOTS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_func,
  input  logic [30:0]                   in_key,
  input  logic signed [31:0]            in_value_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_status,
  output logic signed [31:0]            out_value_out,
  output logic [$clog2(SLOTS):0]        out_live_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [lphm_pkg::LIMIT_W-1:0]  cfg_data
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned LW = IW + 1;
  localparam int unsigned EW = $bits(lphm_pkg::entry_t);
  localparam logic [IW-1:0] IDX_LAST = {IW{1'b1}};

  typedef enum logic [8:0] {
    S_INIT     = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_PROBE    = 9'b000000100,
    S_CLR      = 9'b000001000,
    S_RB_CLR   = 9'b000010000,
    S_RB_SCAN  = 9'b000100000,
    S_RB_EXAM  = 9'b001000000,
    S_RB_PROBE = 9'b010000000,
    S_RESP     = 9'b100000000
  } state_t;

  function automatic logic [IW-1:0] hash_idx(input logic [30:0] k);
    return IW'(k) ^ IW'(k >> IW);
  endfunction

  state_t state_r, state_nxt;
  logic [lphm_pkg::LIMIT_W-1:0] occ_lim_r, tomb_lim_r;
  logic sel_r, sel_nxt;
  logic [LW-1:0] live_r, live_nxt, del_r, del_nxt;
  logic [2:0] func_r, func_nxt;
  logic [30:0] key_r, key_nxt;
  logic [31:0] vin_r, vin_nxt;
  logic [IW-1:0] addr_r, addr_nxt, n_r, n_nxt, cnt_r, cnt_nxt, tomb_r, tomb_nxt;
  logic tomb_v_r, tomb_v_nxt;
  lphm_pkg::entry_t ent_r, ent_nxt;
  logic [2:0] st_r, st_nxt;
  logic [31:0] val_r, val_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [2:0] out_status_r;
  logic [31:0] out_value_r;
  logic [LW-1:0] out_live_r;

  logic we_act, we_ina;
  logic [IW-1:0] waddr_act, waddr_ina, raddr_act, raddr_ina;
  lphm_pkg::entry_t wdata_act, wdata_ina, rd_act, rd_ina;
  logic b0_we, b1_we;
  logic [IW-1:0] b0_waddr, b1_waddr, b0_raddr, b1_raddr;
  logic [EW-1:0] b0_wdata, b1_wdata, b0_rdata, b1_rdata;

  logic hit, is_empty, is_del, stop, free_v, full, load_out;
  logic [IW-1:0] free_idx;
  logic [LW:0] occ_sum;
  logic [LW-1:0] del_inc;
  lphm_pkg::entry_t empty_ent;

  assign empty_ent = '{tag: lphm_pkg::TAG_EMPTY, key: '0, value: '0};

  // Bank steering: the active bank holds the table, the other is the rebuild target.
  assign b0_we    = sel_r ? we_ina : we_act;
  assign b1_we    = sel_r ? we_act : we_ina;
  assign b0_waddr = sel_r ? waddr_ina : waddr_act;
  assign b1_waddr = sel_r ? waddr_act : waddr_ina;
  assign b0_wdata = sel_r ? wdata_ina : wdata_act;
  assign b1_wdata = sel_r ? wdata_act : wdata_ina;
  assign b0_raddr = sel_r ? raddr_ina : raddr_act;
  assign b1_raddr = sel_r ? raddr_act : raddr_ina;
  assign rd_act   = lphm_pkg::entry_t'(sel_r ? b1_rdata : b0_rdata);
  assign rd_ina   = lphm_pkg::entry_t'(sel_r ? b0_rdata : b1_rdata);

  lphm_ram #(.W(EW), .DEPTH(SLOTS)) u_bank0 (
    .clk(clk), .we(b0_we), .waddr(b0_waddr), .wdata(b0_wdata),
    .raddr(b0_raddr), .rdata(b0_rdata)
  );

  lphm_ram #(.W(EW), .DEPTH(SLOTS)) u_bank1 (
    .clk(clk), .we(b1_we), .waddr(b1_waddr), .wdata(b1_wdata),
    .raddr(b1_raddr), .rdata(b1_rdata)
  );

  assign is_empty = (rd_act.tag == lphm_pkg::TAG_EMPTY);
  assign is_del   = (rd_act.tag == lphm_pkg::TAG_DEL);
  assign hit      = (rd_act.tag == lphm_pkg::TAG_LIVE) && (rd_act.key == key_r);
  assign stop     = hit || is_empty || (n_r == IDX_LAST);
  assign free_v   = tomb_v_r || is_empty || is_del;
  assign free_idx = tomb_v_r ? tomb_r : addr_r;
  assign occ_sum  = {1'b0, live_r} + {1'b0, del_r};
  assign full     = !free_v || (occ_sum >= (LW+1)'(occ_lim_r));
  assign del_inc  = del_r + LW'(1);

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign load_out  = (state_r == S_RESP) && (!out_valid_r || !out_stall);
  assign out_valid_nxt = load_out || (out_valid_r && out_stall);

  always_comb begin
    state_nxt  = state_r;
    sel_nxt    = sel_r;
    live_nxt   = live_r;
    del_nxt    = del_r;
    func_nxt   = func_r;
    key_nxt    = key_r;
    vin_nxt    = vin_r;
    addr_nxt   = addr_r;
    n_nxt      = n_r;
    cnt_nxt    = cnt_r;
    tomb_nxt   = tomb_r;
    tomb_v_nxt = tomb_v_r;
    ent_nxt    = ent_r;
    st_nxt     = st_r;
    val_nxt    = val_r;
    we_act     = 1'b0;
    we_ina     = 1'b0;
    waddr_act  = addr_r;
    waddr_ina  = addr_r;
    wdata_act  = empty_ent;
    wdata_ina  = ent_r;
    raddr_act  = addr_r;
    raddr_ina  = addr_r;
    unique case (state_r)
      S_INIT, S_CLR: begin
        we_act    = 1'b1;
        waddr_act = cnt_r;
        cnt_nxt   = cnt_r + IW'(1);
        if (cnt_r == IDX_LAST) begin
          live_nxt  = '0;
          del_nxt   = '0;
          st_nxt    = lphm_pkg::ST_REMOVED;
          val_nxt   = '0;
          state_nxt = (state_r == S_INIT) ? S_IDLE : S_RESP;
        end
      end
      S_IDLE: begin
        raddr_act = hash_idx(in_key);
        if (in_valid) begin
          func_nxt   = in_func;
          key_nxt    = in_key;
          vin_nxt    = in_value_in;
          addr_nxt   = hash_idx(in_key);
          n_nxt      = '0;
          cnt_nxt    = '0;
          tomb_v_nxt = 1'b0;
          st_nxt     = lphm_pkg::ST_ABSENT;
          val_nxt    = '0;
          if (in_func == lphm_pkg::F_CLEAR) begin
            state_nxt = S_CLR;
          end else if (in_func > lphm_pkg::F_CLEAR) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (!stop) begin
          if (is_del && !tomb_v_r) begin
            tomb_v_nxt = 1'b1;
            tomb_nxt   = addr_r;
          end
          addr_nxt  = addr_r + IW'(1);
          raddr_act = addr_r + IW'(1);
          n_nxt     = n_r + IW'(1);
        end else begin
          state_nxt = S_RESP;
          waddr_act = addr_r;
          wdata_act = rd_act;
          unique case (func_r)
            lphm_pkg::F_FIND: begin
              if (hit) begin
                st_nxt  = lphm_pkg::ST_FOUND;
                val_nxt = rd_act.value;
              end
            end
            lphm_pkg::F_INSERT: begin
              if (hit) begin
                st_nxt  = lphm_pkg::ST_FOUND;
                val_nxt = rd_act.value;
              end else if (full) begin
                st_nxt = lphm_pkg::ST_FULL;
              end else begin
                we_act    = 1'b1;
                waddr_act = free_idx;
                wdata_act = '{tag: lphm_pkg::TAG_LIVE, key: key_r,
                              value: lphm_pkg::NEW_VALUE};
                live_nxt  = live_r + LW'(1);
                st_nxt    = lphm_pkg::ST_INSERTED;
                val_nxt   = lphm_pkg::NEW_VALUE;
              end
            end
            lphm_pkg::F_WRITE: begin
              if (hit) begin
                we_act          = 1'b1;
                wdata_act.value = vin_r;
                st_nxt          = lphm_pkg::ST_FOUND;
                val_nxt         = vin_r;
              end
            end
            lphm_pkg::F_ERASE: begin
              if (hit) begin
                we_act        = 1'b1;
                wdata_act.tag = lphm_pkg::TAG_DEL;
                live_nxt      = live_r - LW'(1);
                del_nxt       = del_inc;
                st_nxt        = lphm_pkg::ST_REMOVED;
                if (del_inc > LW'(tomb_lim_r)) begin
                  cnt_nxt   = '0;
                  state_nxt = S_RB_CLR;
                end
              end
            end
            default: begin
              st_nxt = lphm_pkg::ST_ABSENT;
            end
          endcase
        end
      end
      S_RB_CLR: begin
        we_ina    = 1'b1;
        waddr_ina = cnt_r;
        wdata_ina = empty_ent;
        cnt_nxt   = cnt_r + IW'(1);
        if (cnt_r == IDX_LAST) begin
          state_nxt = S_RB_SCAN;
        end
      end
      S_RB_SCAN: begin
        raddr_act = cnt_r;
        state_nxt = S_RB_EXAM;
      end
      S_RB_EXAM: begin
        if (rd_act.tag == lphm_pkg::TAG_LIVE) begin
          ent_nxt   = rd_act;
          addr_nxt  = hash_idx(rd_act.key);
          raddr_ina = hash_idx(rd_act.key);
          state_nxt = S_RB_PROBE;
        end else if (cnt_r == IDX_LAST) begin
          sel_nxt   = !sel_r;
          del_nxt   = '0;
          state_nxt = S_RESP;
        end else begin
          cnt_nxt   = cnt_r + IW'(1);
          state_nxt = S_RB_SCAN;
        end
      end
      S_RB_PROBE: begin
        if (rd_ina.tag == lphm_pkg::TAG_EMPTY) begin
          we_ina    = 1'b1;
          waddr_ina = addr_r;
          if (cnt_r == IDX_LAST) begin
            sel_nxt   = !sel_r;
            del_nxt   = '0;
            state_nxt = S_RESP;
          end else begin
            cnt_nxt   = cnt_r + IW'(1);
            state_nxt = S_RB_SCAN;
          end
        end else begin
          addr_nxt  = addr_r + IW'(1);
          raddr_ina = addr_r + IW'(1);
        end
      end
      S_RESP: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      sel_r       <= 1'b0;
      live_r      <= '0;
      del_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      occ_lim_r   <= lphm_pkg::OCC_LIMIT_RST;
      tomb_lim_r  <= lphm_pkg::TOMB_LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      live_r      <= live_nxt;
      del_r       <= del_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == lphm_pkg::REG_OCC_LIMIT) begin
          occ_lim_r <= cfg_data;
        end else begin
          tomb_lim_r <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    key_r    <= key_nxt;
    vin_r    <= vin_nxt;
    addr_r   <= addr_nxt;
    n_r      <= n_nxt;
    tomb_r   <= tomb_nxt;
    tomb_v_r <= tomb_v_nxt;
    ent_r    <= ent_nxt;
    st_r     <= st_nxt;
    val_r    <= val_nxt;
    if (load_out) begin
      out_status_r <= st_r;
      out_value_r  <= val_r;
      out_live_r   <= live_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_value_out  = out_value_r;
  assign out_live_count = out_live_r;

`include "assert_macros.svh"

  `LPHM_ASSERT(a_state_onehot, $onehot(state_r))
  `LPHM_ASSERT(a_count_bound, ({1'b0, live_r} + {1'b0, del_r}) <= (LW+1)'(SLOTS))
  `LPHM_ASSERT_NEXT(a_resp_loads, (state_r == S_RESP) && !out_valid_r, out_valid_r)
  `LPHM_ASSERT_IMP(a_swap_at_rebuild_end, sel_r != $past(sel_r),
    ($past(state_r) == S_RB_EXAM) || ($past(state_r) == S_RB_PROBE))

endmodule

// File: tb/sv/linear_probe_hash_map_tb.sv
// Self-checking testbench for the linear probing hash map: directed and random requests with a key-value predictor.
module linear_probe_hash_map_tb;

  typedef struct {
    logic [2:0]  func;
    logic [30:0] key;
    logic [31:0] value;
  } map_req_t;

  typedef struct {
    lphm_pkg::status_t status;
    logic [31:0]       value;
    logic [10:0]       live;
  } map_rsp_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [2:0] in_func;
  logic [30:0] in_key;
  logic signed [31:0] in_value_in;
  logic out_valid;
  logic out_stall;
  logic [2:0] out_status;
  logic signed [31:0] out_value_out;
  logic [10:0] out_live_count;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [9:0] cfg_data;

  map_req_t pending_reqs[$];
  map_rsp_t expected_rsps[$];
  map_req_t cur_req;
  logic [31:0] stored_values[logic [30:0]];
  logic [30:0] key_pool[$];
  int unsigned live_entries;
  int unsigned deleted_entries;
  int unsigned occ_limit;
  int unsigned tomb_limit;
  int unsigned errors;
  bit calm;

  linear_probe_hash_map u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_func(in_func), .in_key(in_key), .in_value_in(in_value_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_value_out(out_value_out),
    .out_live_count(out_live_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic map_rsp_t apply_request(map_req_t r);
    map_rsp_t rsp;
    bit present;
    present = stored_values.exists(r.key);
    rsp.status = lphm_pkg::ST_ABSENT;
    rsp.value = '0;
    unique case (r.func)
      lphm_pkg::F_FIND: begin
        if (present) begin
          rsp.status = lphm_pkg::ST_FOUND;
          rsp.value = stored_values[r.key];
        end
      end
      lphm_pkg::F_INSERT: begin
        if (present) begin
          rsp.status = lphm_pkg::ST_FOUND;
          rsp.value = stored_values[r.key];
        end else if (live_entries + deleted_entries >= occ_limit) begin
          rsp.status = lphm_pkg::ST_FULL;
        end else begin
          stored_values[r.key] = lphm_pkg::NEW_VALUE;
          live_entries++;
          rsp.status = lphm_pkg::ST_INSERTED;
          rsp.value = lphm_pkg::NEW_VALUE;
        end
      end
      lphm_pkg::F_WRITE: begin
        if (present) begin
          stored_values[r.key] = r.value;
          rsp.status = lphm_pkg::ST_FOUND;
          rsp.value = r.value;
        end
      end
      lphm_pkg::F_ERASE: begin
        if (present) begin
          stored_values.delete(r.key);
          live_entries--;
          deleted_entries++;
          if (deleted_entries > tomb_limit) deleted_entries = 0;
          rsp.status = lphm_pkg::ST_REMOVED;
        end
      end
      lphm_pkg::F_CLEAR: begin
        stored_values.delete();
        live_entries = 0;
        deleted_entries = 0;
        rsp.status = lphm_pkg::ST_REMOVED;
      end
      default: ;
    endcase
    rsp.live = live_entries[10:0];
    return rsp;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_func <= '0;
      in_key <= '0;
      in_value_in <= '0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) expected_rsps.push_back(apply_request(cur_req));
      if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 28)) begin
        cur_req = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_func <= cur_req.func;
        in_key <= cur_req.key;
        in_value_in <= cur_req.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    map_rsp_t exp_rsp;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_rsps.size() == 0) begin
          $error("Response arrived with no request outstanding.");
          errors++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (out_status !== exp_rsp.status) begin
            $error("status: expected %0d, actual %0d", exp_rsp.status, out_status);
            errors++;
          end
          if (out_value_out !== exp_rsp.value) begin
            $error("value_out: expected %0d, actual %0d",
                   $signed(exp_rsp.value), out_value_out);
            errors++;
          end
          if (out_live_count !== exp_rsp.live) begin
            $error("live_count: expected %0d, actual %0d", exp_rsp.live, out_live_count);
            errors++;
          end
        end
      end
      out_stall <= !calm && ($urandom_range(99) < 28);
    end
  end

  task automatic push_req(logic [2:0] func, logic [30:0] key, logic [31:0] value);
    map_req_t r;
    r.func = func;
    r.key = key;
    r.value = value;
    pending_reqs.push_back(r);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0);
  endtask

  task automatic write_reg(lphm_pkg::reg_idx_t idx, logic [9:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == lphm_pkg::REG_OCC_LIMIT) occ_limit = 32'(data);
    else tomb_limit = 32'(data);
  endtask

  task automatic fill_random(int unsigned count);
    int unsigned pick;
    int unsigned pool_size;
    logic [30:0] key;
    pool_size = $urandom_range(60, 6);
    key_pool.delete();
    for (int i = 0; i < pool_size; i++) key_pool.push_back(31'($urandom()));
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      key = ($urandom_range(9) == 0) ? 31'($urandom()) :
            key_pool[$urandom_range(pool_size - 1)];
      if (pick < 35) push_req(lphm_pkg::F_INSERT, key, $urandom());
      else if (pick < 55) push_req(lphm_pkg::F_FIND, key, $urandom());
      else if (pick < 72) push_req(lphm_pkg::F_WRITE, key, $urandom());
      else if (pick < 95) push_req(lphm_pkg::F_ERASE, key, $urandom());
      else if (pick < 97) push_req(lphm_pkg::F_CLEAR, key, $urandom());
      else push_req(3'($urandom_range(7, 5)), key, $urandom());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = '0;
    in_key = '0;
    in_value_in = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = lphm_pkg::REG_OCC_LIMIT;
    cfg_data = '0;
    errors = 0;
    calm = 1'b0;
    live_entries = 0;
    deleted_entries = 0;
    occ_limit = 32'(lphm_pkg::OCC_LIMIT_RST);
    tomb_limit = 32'(lphm_pkg::TOMB_LIMIT_RST);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    push_req(lphm_pkg::F_FIND, 31'd0, 32'd0);
    push_req(lphm_pkg::F_INSERT, 31'd0, 32'd0);
    push_req(lphm_pkg::F_INSERT, 31'h7FFF_FFFF, 32'd0);
    push_req(lphm_pkg::F_INSERT, 31'h7FFF_FFFF, 32'd0);
    push_req(lphm_pkg::F_WRITE, 31'd0, 32'h7FFF_FFFF);
    push_req(lphm_pkg::F_WRITE, 31'h7FFF_FFFF, 32'h8000_0000);
    push_req(lphm_pkg::F_FIND, 31'd0, 32'd0);
    push_req(lphm_pkg::F_FIND, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    push_req(lphm_pkg::F_WRITE, 31'h1234_5678, 32'h5555_5555);
    push_req(lphm_pkg::F_ERASE, 31'h1234_5678, 32'd0);
    push_req(lphm_pkg::F_ERASE, 31'd0, 32'd0);
    push_req(lphm_pkg::F_FIND, 31'd0, 32'd0);
    push_req(lphm_pkg::F_INSERT, 31'd0, 32'd0);
    push_req(3'd5, 31'd0, 32'd0);
    push_req(3'd6, 31'h2AAA_AAAA, 32'hAAAA_AAAA);
    push_req(3'd7, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    push_req(lphm_pkg::F_CLEAR, 31'h5555_5555, 32'd0);
    push_req(lphm_pkg::F_FIND, 31'h7FFF_FFFF, 32'd0);
    wait_idle();

    // Small limits: refused inserts and a rebuild on every erase that removes an entry.
    write_reg(lphm_pkg::REG_OCC_LIMIT, 10'd1);
    write_reg(lphm_pkg::REG_TOMB_LIMIT, 10'd0);
    push_req(lphm_pkg::F_INSERT, 31'd9, 32'd0);
    push_req(lphm_pkg::F_INSERT, 31'd10, 32'd0);
    push_req(lphm_pkg::F_ERASE, 31'd9, 32'd0);
    push_req(lphm_pkg::F_INSERT, 31'd10, 32'd0);
    fill_random(200);
    wait_idle();

    write_reg(lphm_pkg::REG_OCC_LIMIT, 10'd1023);
    write_reg(lphm_pkg::REG_TOMB_LIMIT, 10'd1023);
    calm = 1'b1;
    fill_random(220);
    wait_idle();
    calm = 1'b0;

    write_reg(lphm_pkg::REG_OCC_LIMIT, 10'd16);
    write_reg(lphm_pkg::REG_TOMB_LIMIT, 10'd3);
    fill_random(220);
    wait_idle();

    write_reg(lphm_pkg::REG_OCC_LIMIT, 10'd40);
    write_reg(lphm_pkg::REG_TOMB_LIMIT, 10'd0);
    fill_random(210);
    wait_idle();

    write_reg(lphm_pkg::REG_OCC_LIMIT, 10'd300);
    write_reg(lphm_pkg::REG_TOMB_LIMIT, 10'd50);
    fill_random(210);
    wait_idle();

    write_reg(lphm_pkg::REG_OCC_LIMIT, lphm_pkg::OCC_LIMIT_RST);
    write_reg(lphm_pkg::REG_TOMB_LIMIT, lphm_pkg::TOMB_LIMIT_RST);
    fill_random(200);
    wait_idle();

    repeat (4 * lphm_pkg::SLOTS_DEFAULT) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #240_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
